@@ rtl/tgapd_pkg.sv @@
// ----------------------------------------------------------------------------
// tgapd_pkg
// Shared types and constants of the uncompressed TGA pixel decoder.
// ----------------------------------------------------------------------------
package tgapd_pkg;

   localparam int QUEUE_DEPTH = 2;

   // result kinds
   localparam logic [1:0] KIND_PIXEL   = 2'd0;
   localparam logic [1:0] KIND_HDR_OK  = 2'd1;
   localparam logic [1:0] KIND_HDR_BAD = 2'd2;

   // pixel formats, coded as the index of the last byte of a pixel
   localparam logic [1:0] PIX_GRAY = 2'd0;
   localparam logic [1:0] PIX_RGB  = 2'd2;
   localparam logic [1:0] PIX_RGBA = 2'd3;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

   // header byte offsets
   localparam logic [4:0] HP_ID_LEN    = 5'd0;
   localparam logic [4:0] HP_CMAP_TYPE = 5'd1;
   localparam logic [4:0] HP_IMG_TYPE  = 5'd2;
   localparam logic [4:0] HP_WIDTH_LO  = 5'd12;
   localparam logic [4:0] HP_WIDTH_HI  = 5'd13;
   localparam logic [4:0] HP_HEIGHT_LO = 5'd14;
   localparam logic [4:0] HP_HEIGHT_HI = 5'd15;
   localparam logic [4:0] HP_BPP       = 5'd16;
   localparam logic [4:0] HP_LAST      = 5'd17;

   // accepted image types and pixel sizes
   localparam logic [7:0] IMG_TRUECOLOR = 8'd2;
   localparam logic [7:0] IMG_GRAY      = 8'd3;
   localparam logic [7:0] BPP_8         = 8'd8;
   localparam logic [7:0] BPP_24        = 8'd24;
   localparam logic [7:0] BPP_32        = 8'd32;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_file;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] pixel_index;
      logic [31:0] pixel_color;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic        last_of_image;
   } rsp_type;

   // work item handed from the parser to the output formatter
   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  pix_mode;
      logic [7:0]  data_byte;
      logic [23:0] partial_color;
      logic [31:0] row_base;
      logic [15:0] column;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic        last_of_image;
   } op_type;

endpackage

@@ rtl/tgapd_front.sv @@
// ----------------------------------------------------------------------------
// tgapd_front
// Byte parser: walks the header, skips the id field, packs pixel bytes and
// keeps the row and column counters. Emits one work item per result.
// ----------------------------------------------------------------------------
module tgapd_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  tgapd_pkg::req_type req_payload,
   output logic               push,
   output tgapd_pkg::op_type  push_op
);
   import tgapd_pkg::*;

   typedef enum logic [3:0] {
      PH_HEADER = 4'b0001,
      PH_IDSKIP = 4'b0010,
      PH_PIXELS = 4'b0100,
      PH_DONE   = 4'b1000
   } phase_type;

   phase_type   phase_ff, phase_in, cur_phase;
   logic [4:0]  pos_ff, pos_in, cur_pos;
   logic [7:0]  id_left_ff, id_left_in;
   logic [7:0]  image_kind_ff, image_kind_in;
   logic [7:0]  palette_kind_ff, palette_kind_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [7:0]  bpp_ff, bpp_in;
   logic [1:0]  pix_mode_ff, pix_mode_in;
   logic [1:0]  bip_ff, bip_in;
   logic [23:0] partial_ff, partial_in;
   logic [15:0] row_ff, row_in;
   logic [15:0] col_ff, col_in;
   logic [31:0] row_base_ff, row_base_in;
   logic [31:0] prod_ff, prod_in;
   logic [15:0] height_m1;
   logic [16:0] col_next;
   logic [7:0]  b;
   logic        hdr_ok;

   assign b         = req_payload.data_byte;
   assign cur_phase = req_payload.start_of_file ? PH_HEADER : phase_ff;
   assign cur_pos   = req_payload.start_of_file ? HP_ID_LEN : pos_ff;
   assign height_m1 = height_ff - 16'd1;
   assign col_next  = {1'b0, col_ff} + 17'd1;
   assign hdr_ok    = (image_kind_ff == IMG_TRUECOLOR || image_kind_ff == IMG_GRAY)
                      && palette_kind_ff == 8'd0
                      && (bpp_ff == BPP_8 || bpp_ff == BPP_24 || bpp_ff == BPP_32);

   always_comb begin
      phase_in        = phase_ff;
      pos_in          = pos_ff;
      id_left_in      = id_left_ff;
      image_kind_in   = image_kind_ff;
      palette_kind_in = palette_kind_ff;
      width_in        = width_ff;
      height_in       = height_ff;
      bpp_in          = bpp_ff;
      pix_mode_in     = pix_mode_ff;
      bip_in          = bip_ff;
      partial_in      = partial_ff;
      row_in          = row_ff;
      col_in          = col_ff;
      row_base_in     = row_base_ff;
      prod_in         = prod_ff;
      push            = 1'b0;
      push_op.kind          = KIND_PIXEL;
      push_op.pix_mode      = pix_mode_ff;
      push_op.data_byte     = b;
      push_op.partial_color = partial_ff;
      push_op.row_base      = row_base_ff;
      push_op.column        = col_ff;
      push_op.image_width   = width_ff;
      push_op.image_height  = height_ff;
      push_op.last_of_image = 1'b0;
      if (accept) begin
         case (cur_phase)
            PH_HEADER: begin
               phase_in = PH_HEADER;
               case (cur_pos)
                  HP_ID_LEN:    id_left_in = b;
                  HP_CMAP_TYPE: palette_kind_in = b;
                  HP_IMG_TYPE:  image_kind_in = b;
                  HP_WIDTH_LO:  width_in = {width_ff[15:8], b};
                  HP_WIDTH_HI:  width_in = {b, width_ff[7:0]};
                  HP_HEIGHT_LO: height_in = {height_ff[15:8], b};
                  HP_HEIGHT_HI: height_in = {b, height_ff[7:0]};
                  HP_BPP: begin
                     bpp_in  = b;
                     prod_in = 32'(height_m1) * 32'(width_ff);
                  end
                  default: ;
               endcase
               if (cur_pos != HP_LAST) begin
                  pos_in = cur_pos + 5'd1;
               end else begin
                  pos_in = HP_ID_LEN;
                  push   = 1'b1;
                  if (!hdr_ok) begin
                     phase_in              = PH_DONE;
                     push_op.kind          = KIND_HDR_BAD;
                     push_op.last_of_image = 1'b1;
                  end else if (width_ff == 16'd0 || height_ff == 16'd0) begin
                     phase_in              = PH_DONE;
                     push_op.kind          = KIND_HDR_OK;
                     push_op.last_of_image = 1'b1;
                  end else begin
                     push_op.kind = KIND_HDR_OK;
                     row_in       = height_m1;
                     col_in       = 16'd0;
                     row_base_in  = prod_ff;
                     bip_in       = 2'd0;
                     partial_in   = 24'd0;
                     if (bpp_ff == BPP_8) begin
                        pix_mode_in = PIX_GRAY;
                     end else if (bpp_ff == BPP_24) begin
                        pix_mode_in = PIX_RGB;
                     end else begin
                        pix_mode_in = PIX_RGBA;
                     end
                     phase_in = (id_left_ff != 8'd0) ? PH_IDSKIP : PH_PIXELS;
                  end
               end
            end
            PH_IDSKIP: begin
               id_left_in = id_left_ff - 8'd1;
               if (id_left_ff == 8'd1) begin
                  phase_in = PH_PIXELS;
               end
            end
            PH_PIXELS: begin
               if (bip_ff < pix_mode_ff) begin
                  case (bip_ff)
                     2'd0:    partial_in[7:0]   = b;
                     2'd1:    partial_in[15:8]  = b;
                     default: partial_in[23:16] = b;
                  endcase
                  bip_in = bip_ff + 2'd1;
               end else begin
                  push                  = 1'b1;
                  push_op.last_of_image = (row_ff == 16'd0) && (col_next == {1'b0, width_ff});
                  bip_in                = 2'd0;
                  partial_in            = 24'd0;
                  if (col_next >= {1'b0, width_ff}) begin
                     col_in = 16'd0;
                     if (row_ff == 16'd0) begin
                        phase_in = PH_DONE;
                     end else begin
                        row_in      = row_ff - 16'd1;
                        row_base_in = row_base_ff - 32'(width_ff);
                     end
                  end else begin
                     col_in = col_next[15:0];
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         pos_ff          <= HP_ID_LEN;
         id_left_ff      <= '0;
         image_kind_ff   <= '0;
         palette_kind_ff <= '0;
         width_ff        <= '0;
         height_ff       <= '0;
         bpp_ff          <= '0;
         pix_mode_ff     <= PIX_GRAY;
         bip_ff          <= '0;
         partial_ff      <= '0;
         row_ff          <= '0;
         col_ff          <= '0;
         row_base_ff     <= '0;
         prod_ff         <= '0;
      end else begin
         phase_ff        <= phase_in;
         pos_ff          <= pos_in;
         id_left_ff      <= id_left_in;
         image_kind_ff   <= image_kind_in;
         palette_kind_ff <= palette_kind_in;
         width_ff        <= width_in;
         height_ff       <= height_in;
         bpp_ff          <= bpp_in;
         pix_mode_ff     <= pix_mode_in;
         bip_ff          <= bip_in;
         partial_ff      <= partial_in;
         row_ff          <= row_in;
         col_ff          <= col_in;
         row_base_ff     <= row_base_in;
         prod_ff         <= prod_in;
      end
   end

   // header results only come out on the last header byte
   assert property (@(posedge clock) disable iff (reset)
      (push && push_op.kind != KIND_PIXEL) |-> (cur_pos == HP_LAST))
      else $error("header result away from last header byte");

   // the pixel column stays inside the image row
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PIXELS) |-> (col_ff < width_ff))
      else $error("column counter beyond image width");

endmodule

@@ rtl/tgapd_queue.sv @@
// ----------------------------------------------------------------------------
// tgapd_queue
// Short work queue between the parser and the output formatter.
// ----------------------------------------------------------------------------
module tgapd_queue #(
   parameter int DEPTH = tgapd_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tgapd_pkg::op_type push_op,
   input  logic              pop,
   output tgapd_pkg::op_type head_op,
   output logic              empty,
   output logic              full
);
   import tgapd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   op_type           entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_FULL);
   assign head_op = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_op;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");

   assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("pop from empty queue");

endmodule

@@ rtl/tgapd_back.sv @@
// ----------------------------------------------------------------------------
// tgapd_back
// Output formatter: expands pixels to 32-bit colors, adds the column to the
// row base and holds the result in the output register.
// ----------------------------------------------------------------------------
module tgapd_back (
   input  logic               clock,
   input  logic               reset,
   input  tgapd_pkg::op_type  head_op,
   input  logic               empty,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output tgapd_pkg::rsp_type rsp_payload
);
   import tgapd_pkg::*;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    load;
   logic [31:0] color;

   assign load = !rsp_valid_ff || !rsp_stall;
   assign pop  = load && !empty;

   always_comb begin
      case (head_op.pix_mode)
         PIX_GRAY: color = {ALPHA_OPAQUE, head_op.data_byte, head_op.data_byte,
                            head_op.data_byte};
         PIX_RGB:  color = {ALPHA_OPAQUE, head_op.data_byte,
                            head_op.partial_color[15:0]};
         default:  color = {head_op.data_byte, head_op.partial_color};
      endcase
   end

   always_comb begin
      rsp_valid_in         = load ? !empty : rsp_valid_ff;
      rsp_in               = rsp_ff;
      if (pop) begin
         rsp_in.kind          = head_op.kind;
         rsp_in.image_width   = head_op.image_width;
         rsp_in.image_height  = head_op.image_height;
         rsp_in.last_of_image = head_op.last_of_image;
         if (head_op.kind == KIND_PIXEL) begin
            rsp_in.pixel_index = head_op.row_base + 32'(head_op.column);
            rsp_in.pixel_color = color;
         end else begin
            rsp_in.pixel_index = 32'd0;
            rsp_in.pixel_color = 32'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ rtl/tga_uncompressed_pixel_decoder.sv @@
// ----------------------------------------------------------------------------
// tga_uncompressed_pixel_decoder
// Uncompressed TGA decoder: header check, id skip, pixel expansion and
// bottom-up destination indexing.
// ----------------------------------------------------------------------------
// The decoder takes one file byte per clock cycle while the work queue is not
// full. A result (header verdict or pixel) goes through the work queue into
// the output register: the parser decodes the byte that completes it and
// writes the queue as it accepts that byte, and the output formatter loads
// the output register once it is free. The input is stalled only when the
// work queue is full, which happens only while the result side holds its own
// stall; with the result side free the decoder sustains one byte per cycle
// without a gap, including across headers, id fields and pixel boundaries.
module tga_uncompressed_pixel_decoder #(
   parameter int QUEUE_DEPTH = tgapd_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  tgapd_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output tgapd_pkg::rsp_type rsp_payload
);
   import tgapd_pkg::*;

   logic   accept;
   logic   push;
   logic   pop;
   logic   empty;
   logic   full;
   op_type push_op;
   op_type head_op;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   tgapd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_payload (req_payload),
      .push        (push),
      .push_op     (push_op)
   );

   tgapd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .head_op (head_op),
      .empty   (empty),
      .full    (full)
   );

   tgapd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_op     (head_op),
      .empty       (empty),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
